>>> design/slp_pkg.sv
// Shared types and constants for the serial link port.
`default_nettype none

package slp_pkg;

  // Request function codes.
  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Register selects.
  localparam logic SEL_DATA    = 1'b0;
  localparam logic SEL_CONTROL = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_LINK_MODE    = 1'b0;
  localparam logic CFG_CLASSIC_MODE = 1'b1;

  // Tick dividers for the shift clock.
  localparam int SLOW_DIVIDER = 512;
  localparam int FAST_DIVIDER = 16;
  localparam int TICK_W       = 10;

  // Control register masks: start and internal clock, plus fast clock.
  localparam logic [7:0] CTRL_MASK         = 8'h83;
  localparam logic [7:0] CTRL_MASK_CLASSIC = 8'h81;
  localparam logic [7:0] START_INTCLK      = 8'h81;
  localparam logic [7:0] CLEAR_START       = 8'h7F;
  localparam logic [7:0] RESET_INCOMING    = 8'hFF;

  // One result of a request.
  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
  } result_t;

endpackage

`default_nettype wire

>>> design/slp_core.sv
// Serial port register state and the combinational update for one request.
`default_nettype none

module slp_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic             cfg_wdata,
  input  wire logic             step,
  input  wire logic [1:0]       func,
  input  wire logic             reg_sel,
  input  wire logic [7:0]       wdata,
  output slp_pkg::result_t      result
);

  logic                        link_mode;
  logic                        classic_mode;
  logic [7:0]                  data_byte;
  logic [7:0]                  control_bits;
  logic                        fast_clock;
  logic [slp_pkg::TICK_W-1:0]  tick_count;
  logic [2:0]                  bit_index;
  logic [7:0]                  incoming_byte;

  logic [7:0]                  data_byte_next;
  logic [7:0]                  control_bits_next;
  logic                        fast_clock_next;
  logic [slp_pkg::TICK_W-1:0]  tick_count_next;
  logic [2:0]                  bit_index_next;
  logic [7:0]                  incoming_byte_next;

  logic [7:0]                  mask;
  logic [7:0]                  ctrl_written;
  logic [slp_pkg::TICK_W:0]    tick_inc;
  logic [slp_pkg::TICK_W:0]    divider;
  logic                        rx_bit;

  // Writable control bits depend on the console model.
  assign mask         = classic_mode ? slp_pkg::CTRL_MASK_CLASSIC : slp_pkg::CTRL_MASK;
  assign ctrl_written = (control_bits & ~mask) | (wdata & mask);
  assign tick_inc     = {1'b0, tick_count} + 1'b1;
  assign divider      = fast_clock ? (slp_pkg::TICK_W+1)'(slp_pkg::FAST_DIVIDER)
                                   : (slp_pkg::TICK_W+1)'(slp_pkg::SLOW_DIVIDER);
  assign rx_bit       = incoming_byte[3'd7 - bit_index];

  // Next state and result for the current request.
  always_comb begin
    data_byte_next     = data_byte;
    control_bits_next  = control_bits;
    fast_clock_next    = fast_clock;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    incoming_byte_next = incoming_byte;
    result.rdata       = 8'h00;
    result.irq         = 1'b0;
    unique case (func)
      slp_pkg::FUNC_WRITE: begin
        if (reg_sel == slp_pkg::SEL_DATA) begin
          data_byte_next = wdata;
        end else if (link_mode) begin
          // Loopback finishes the transfer at once.
          control_bits_next = ctrl_written & slp_pkg::CLEAR_START;
          result.irq        = 1'b1;
        end else begin
          control_bits_next = ctrl_written;
          fast_clock_next   = wdata[1];
          if ((wdata & slp_pkg::START_INTCLK) == slp_pkg::START_INTCLK) begin
            incoming_byte_next = slp_pkg::RESET_INCOMING;
          end
        end
      end
      slp_pkg::FUNC_READ: begin
        if (reg_sel == slp_pkg::SEL_DATA) begin
          result.rdata = data_byte;
        end else begin
          result.rdata = (control_bits & mask) | ~mask;
        end
      end
      slp_pkg::FUNC_TICK: begin
        // Shift one bit in each time the divider expires during a transfer.
        if ((control_bits & slp_pkg::START_INTCLK) == slp_pkg::START_INTCLK) begin
          if (tick_inc < divider) begin
            tick_count_next = tick_inc[slp_pkg::TICK_W-1:0];
          end else begin
            tick_count_next = '0;
            data_byte_next  = {data_byte[6:0], rx_bit};
            bit_index_next  = bit_index + 3'd1;
            if (bit_index == 3'd7) begin
              control_bits_next = control_bits & slp_pkg::CLEAR_START;
              result.irq        = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // State registers and configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      link_mode     <= 1'b0;
      classic_mode  <= 1'b0;
      data_byte     <= 8'h00;
      control_bits  <= 8'h00;
      fast_clock    <= 1'b0;
      tick_count    <= '0;
      bit_index     <= 3'd0;
      incoming_byte <= slp_pkg::RESET_INCOMING;
    end else begin
      if (cfg_we) begin
        if (cfg_index == slp_pkg::CFG_LINK_MODE) begin
          link_mode <= cfg_wdata;
        end else begin
          classic_mode <= cfg_wdata;
        end
      end
      if (step) begin
        data_byte     <= data_byte_next;
        control_bits  <= control_bits_next;
        fast_clock    <= fast_clock_next;
        tick_count    <= tick_count_next;
        bit_index     <= bit_index_next;
        incoming_byte <= incoming_byte_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/slp_out.sv
// Result register that holds one result until the consumer takes it.
`default_nettype none

module slp_out (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire slp_pkg::result_t result,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic                  can_load,
  output logic [7:0]            rdata,
  output logic                  irq
);

  slp_pkg::result_t held;

  // A new result may enter when the register is empty or being drained.
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      held <= result;
    end
  end

  assign rdata = held.rdata;
  assign irq   = held.irq;

endmodule

`default_nettype wire

>>> design/serial_link_port_top.sv
// Top level of the serial link port.
//
//  channel   direction  handshake            payload
//  request   in         in_valid / in_ready  func, reg_sel, wdata
//  result    out        out_valid/out_ready  rdata, irq
//  config    in         cfg_we               cfg_index, cfg_wdata
//
// A new request is accepted every cycle while the result register is empty
// or being drained. Its result is registered and appears in the cycle after
// acceptance. Reset is synchronous and clears all state except the held
// result. While a result waits, in_ready drops and the state holds.
`default_nettype none

module serial_link_port_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] func,
  input  wire logic       reg_sel,
  input  wire logic [7:0] wdata,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      rdata,
  output logic            irq,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic       cfg_wdata
);

  slp_pkg::result_t result;
  logic             step;

  assign step = in_valid && in_ready;

  // Register state and per-request update.
  slp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .func      (func),
    .reg_sel   (reg_sel),
    .wdata     (wdata),
    .result    (result)
  );

  // Result register.
  slp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (in_valid),
    .result    (result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (in_ready),
    .rdata     (rdata),
    .irq       (irq)
  );

endmodule

`default_nettype wire

>>> design/slp_checker.sv
// Port-level checks for the serial link port, bound to the top level.
`default_nettype none

module slp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] func,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] rdata,
  input wire logic       irq
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rdata) && $stable(irq))
    else $error("stalled result changed");

  // Every accepted request yields a result in the next cycle.
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  // An empty result register never blocks requests.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request stalled with empty output");

  // Only reads carry data.
  a_rdata: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func != slp_pkg::FUNC_READ |=> rdata == 8'h00)
    else $error("non-read request returned data");

  // Reads never raise the interrupt.
  a_irq: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == slp_pkg::FUNC_READ |=> !irq)
    else $error("read raised the interrupt");

endmodule

bind serial_link_port_top slp_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .func      (func),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .rdata     (rdata),
  .irq       (irq)
);

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the serial link port: directed and random requests against a built-in predictor.
`default_nettype none

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  // Slowest run is well under this: every request waiting out the longest
  // sender gap and receiver stall, plus the long slow-divider segment.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 30;
  localparam int MAX_PRINTED  = 50;

  typedef struct packed {
    logic [1:0] func;
    logic       sel;
    logic [7:0] wdata;
  } port_req_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] func = slp_pkg::FUNC_READ;
  logic       reg_sel = slp_pkg::SEL_DATA;
  logic [7:0] wdata = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] rdata;
  logic       irq;
  logic       cfg_we = 1'b0;
  logic       cfg_index = slp_pkg::CFG_LINK_MODE;
  logic       cfg_wdata = 1'b0;

  // Requests still to be sent, and results still owed by the port.
  port_req_t        queued_requests[$];
  slp_pkg::result_t owed_results[$];
  int               issued_cnt = 0;
  int               accepted_cnt = 0;
  int               result_cnt = 0;
  int               mismatches = 0;
  int               cycles = 0;

  // Predicted port state and configuration.
  logic       mdl_link = 1'b0;
  logic       mdl_classic = 1'b0;
  logic [7:0] mdl_data = 8'h00;
  logic [7:0] mdl_ctrl = 8'h00;
  logic       mdl_fast = 1'b0;
  logic [9:0] mdl_ticks = '0;
  logic [2:0] mdl_bit = '0;
  logic [7:0] mdl_incoming = slp_pkg::RESET_INCOMING;

  serial_link_port_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .reg_sel   (reg_sel),
    .wdata     (wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rdata     (rdata),
    .irq       (irq),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Advance the predicted port by one request and return its result.
  task automatic predict_port_step(input port_req_t req, output slp_pkg::result_t res);
    logic [7:0] mask;
    int         nxt_count;
    int         divider;
    mask = mdl_classic ? slp_pkg::CTRL_MASK_CLASSIC : slp_pkg::CTRL_MASK;
    res = '0;
    case (req.func)
      slp_pkg::FUNC_WRITE: begin
        if (req.sel == slp_pkg::SEL_DATA) begin
          mdl_data = req.wdata;
        end else begin
          mdl_ctrl = (mdl_ctrl & ~mask) | (req.wdata & mask);
          if (mdl_link) begin
            // Loopback finishes the transfer on the spot.
            mdl_ctrl = mdl_ctrl & slp_pkg::CLEAR_START;
            res.irq = 1'b1;
          end else begin
            // The divider follows the raw bit, even when classic mode masks it.
            mdl_fast = req.wdata[1];
            if ((req.wdata & slp_pkg::START_INTCLK) == slp_pkg::START_INTCLK)
              mdl_incoming = slp_pkg::RESET_INCOMING;
          end
        end
      end
      slp_pkg::FUNC_READ: begin
        if (req.sel == slp_pkg::SEL_DATA) res.rdata = mdl_data;
        else res.rdata = (mdl_ctrl & mask) | ~mask;
      end
      slp_pkg::FUNC_TICK: begin
        if ((mdl_ctrl & slp_pkg::START_INTCLK) == slp_pkg::START_INTCLK) begin
          divider = mdl_fast ? slp_pkg::FAST_DIVIDER : slp_pkg::SLOW_DIVIDER;
          nxt_count = int'(mdl_ticks) + 1;
          if (nxt_count < divider) begin
            mdl_ticks = nxt_count[9:0];
          end else begin
            // Shift in one received bit, most significant first.
            mdl_ticks = '0;
            mdl_data = {mdl_data[6:0], mdl_incoming[3'd7 - mdl_bit]};
            mdl_bit = mdl_bit + 3'd1;
            if (mdl_bit == 3'd0) begin
              mdl_ctrl = mdl_ctrl & slp_pkg::CLEAR_START;
              res.irq = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("mismatch at result %0d: %s", result_cnt, what);
  endtask

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 10));
  endfunction

  // Drive requests from the queue, predicting each one as it is accepted.
  always @(posedge clk) begin : drive_requests
    port_req_t        cur_req;
    port_req_t        nxt_req;
    slp_pkg::result_t want;
    int               send_wait;
    bit               send_calm;
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
      send_calm = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_port_step(cur_req, want);
        owed_results.push_back(want);
        accepted_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (queued_requests.size() > 0) begin
          nxt_req = queued_requests.pop_front();
          cur_req = nxt_req;
          in_valid <= 1'b1;
          func <= nxt_req.func;
          reg_sel <= nxt_req.sel;
          wdata <= nxt_req.wdata;
          if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
          send_wait = draw_wait(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Accept results with random stalls and check them in order.
  always @(posedge clk) begin : check_results
    slp_pkg::result_t want;
    int               recv_wait;
    bit               recv_calm;
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait = 0;
      recv_calm = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result rdata=%h irq=%b", rdata, irq));
        end else begin
          want = owed_results.pop_front();
          if (rdata !== want.rdata)
            report_mismatch($sformatf("rdata %h, expected %h", rdata, want.rdata));
          if (irq !== want.irq)
            report_mismatch($sformatf("irq %b, expected %b", irq, want.irq));
        end
        result_cnt++;
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        recv_wait = draw_wait(recv_calm);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_req(input logic [1:0] f, input logic s, input logic [7:0] d);
    port_req_t req;
    req.func = f;
    req.sel = s;
    req.wdata = d;
    queued_requests.push_back(req);
    issued_cnt++;
  endtask

  // A run of ticks with the odd register read mixed in.
  task automatic queue_ticks(input int count);
    for (int i = 0; i < count; i++) begin
      push_req(slp_pkg::FUNC_TICK, slp_pkg::SEL_DATA, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 15) == 0)
        push_req(slp_pkg::FUNC_READ, 1'($urandom_range(0, 1)), 8'h00);
    end
  endtask

  task automatic write_cfg(input logic idx, input logic val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == slp_pkg::CFG_LINK_MODE) mdl_link = val;
    else mdl_classic = val;
  endtask

  task automatic set_mode(input logic link, input logic classic);
    write_cfg(slp_pkg::CFG_LINK_MODE, link);
    write_cfg(slp_pkg::CFG_CLASSIC_MODE, classic);
  endtask

  // Wait until every request has been sent and answered.
  task automatic wait_idle();
    do @(negedge clk);
    while (accepted_cnt != issued_cnt || owed_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Mostly complete transfers with random content, the rest stray requests.
  task automatic queue_random_phase(input int budget);
    int         first;
    int         xfer_ticks;
    logic [7:0] ctl;
    first = issued_cnt;
    // Loopback never leaves a transfer running, so long tick runs only idle there.
    xfer_ticks = mdl_link ? 4 : 8 * slp_pkg::FAST_DIVIDER;
    while (issued_cnt - first < budget) begin
      ctl = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          push_req(slp_pkg::FUNC_WRITE, slp_pkg::SEL_CONTROL, ctl | slp_pkg::CTRL_MASK);
          queue_ticks(xfer_ticks + int'($urandom_range(0, 8)));
          push_req(slp_pkg::FUNC_READ, slp_pkg::SEL_DATA, 8'h00);
          push_req(slp_pkg::FUNC_READ, slp_pkg::SEL_CONTROL, 8'h00);
        end
        4: begin
          // Slow count in progress, then the divider is shortened.
          push_req(slp_pkg::FUNC_WRITE, slp_pkg::SEL_CONTROL,
                   (ctl | slp_pkg::START_INTCLK) & 8'hFD);
          queue_ticks(int'($urandom_range(slp_pkg::FAST_DIVIDER + 1, 60)));
          push_req(slp_pkg::FUNC_WRITE, slp_pkg::SEL_CONTROL, ctl | slp_pkg::CTRL_MASK);
          queue_ticks(xfer_ticks);
          push_req(slp_pkg::FUNC_READ, slp_pkg::SEL_DATA, 8'h00);
        end
        5: begin
          // Start without the internal clock never shifts.
          push_req(slp_pkg::FUNC_WRITE, slp_pkg::SEL_CONTROL, (ctl | 8'h80) & 8'hFE);
          queue_ticks(int'($urandom_range(1, 20)));
          push_req(slp_pkg::FUNC_READ, slp_pkg::SEL_CONTROL, 8'h00);
        end
        6: begin
          push_req(slp_pkg::FUNC_WRITE, slp_pkg::SEL_DATA, ctl);
          push_req(slp_pkg::FUNC_READ, slp_pkg::SEL_DATA, 8'($urandom_range(0, 255)));
        end
        default: begin
          repeat ($urandom_range(4, 16))
            push_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  // Test sequence.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: register extremes, every function, start and clock corners.
    set_mode(1'b0, 1'b0);
    push_req(slp_pkg::FUNC_READ, slp_pkg::SEL_DATA, 8'h00);
    push_req(slp_pkg::FUNC_READ, slp_pkg::SEL_CONTROL, 8'hFF);
    push_req(slp_pkg::FUNC_UNUSED, slp_pkg::SEL_CONTROL, 8'hFF);
    push_req(slp_pkg::FUNC_WRITE, slp_pkg::SEL_DATA, 8'hFF);
    push_req(slp_pkg::FUNC_READ, slp_pkg::SEL_DATA, 8'h00);
    push_req(slp_pkg::FUNC_WRITE, slp_pkg::SEL_DATA, 8'h00);
    push_req(slp_pkg::FUNC_READ, slp_pkg::SEL_DATA, 8'h00);
    push_req(slp_pkg::FUNC_WRITE, slp_pkg::SEL_CONTROL, 8'hFF);
    push_req(slp_pkg::FUNC_READ, slp_pkg::SEL_CONTROL, 8'h00);
    queue_ticks(slp_pkg::FAST_DIVIDER);
    push_req(slp_pkg::FUNC_READ, slp_pkg::SEL_DATA, 8'h00);
    push_req(slp_pkg::FUNC_WRITE, slp_pkg::SEL_CONTROL, 8'h80);
    push_req(slp_pkg::FUNC_TICK, slp_pkg::SEL_CONTROL, 8'hFF);
    push_req(slp_pkg::FUNC_TICK, slp_pkg::SEL_DATA, 8'h00);
    push_req(slp_pkg::FUNC_READ, slp_pkg::SEL_CONTROL, 8'h00);
    // Leave a transfer running into the loopback phase.
    push_req(slp_pkg::FUNC_WRITE, slp_pkg::SEL_CONTROL, 8'h83);
    queue_ticks(50);
    wait_idle();

    // Loopback: the running transfer keeps shifting on ticks.
    set_mode(1'b1, 1'b0);
    queue_ticks(30);
    queue_random_phase(RANDOM_ITEMS);
    wait_idle();

    set_mode(1'b1, 1'b1);
    queue_random_phase(RANDOM_ITEMS);
    wait_idle();

    set_mode(1'b0, 1'b1);
    queue_random_phase(RANDOM_ITEMS);
    wait_idle();

    // One bit at the slow divider.
    set_mode(1'b0, 1'b0);
    push_req(slp_pkg::FUNC_WRITE, slp_pkg::SEL_CONTROL, 8'h81);
    queue_ticks(slp_pkg::SLOW_DIVIDER + 4);
    push_req(slp_pkg::FUNC_READ, slp_pkg::SEL_DATA, 8'h00);
    push_req(slp_pkg::FUNC_READ, slp_pkg::SEL_CONTROL, 8'h00);
    wait_idle();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
